### hdl/ptas_pkg.sv
`default_nettype none

package ptas_pkg;

    localparam int unsigned C_NUM_W   = 70;
    localparam int unsigned C_DEN_W   = 37;
    localparam int unsigned C_RD_W    = 54;
    localparam int unsigned C_ROOT_W  = 17;
    localparam int unsigned C_TERM_W  = 72;
    localparam int unsigned C_STAGES  = 17;

    localparam logic [19:0] C_IAS_NUM = 20'd800000;
    localparam logic [5:0]  C_IAS_DEN = 6'd49;
    localparam logic [18:0] C_TAS_NUM = 19'd287052;
    localparam logic [2:0]  C_TAS_DEN = 3'd5;
    localparam logic [21:0] C_COR_NUM = 22'd3516387;
    localparam logic [19:0] C_COR_DEN = 20'd1000000;
    localparam logic [16:0] C_T_ZERO  = 17'd27315;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NEG  = 2'd1,
        ST_ZERO = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    typedef struct packed {
        logic [C_NUM_W-1:0]  rem;
        logic [C_RD_W-1:0]   rd;
        logic [C_DEN_W-1:0]  d;
        logic [C_ROOT_W-1:0] r;
    } t_lane;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_side;

    // one restoring step: try root bit k, keeping rem = N - r*r*D and rd = r*D
    function automatic t_lane f_root_step(t_lane a, logic [4:0] k);
        logic [C_TERM_W-1:0] term;
        logic [C_TERM_W-1:0] rem_x;
        t_lane               b;
        term  = (C_TERM_W'(a.rd) << (k + 5'd1)) + (C_TERM_W'(a.d) << {k, 1'b0});
        rem_x = C_TERM_W'(a.rem);
        b     = a;
        if (term <= rem_x) begin
            b.rem = C_NUM_W'(rem_x - term);
            b.rd  = a.rd + C_RD_W'(C_TERM_W'(a.d) << k);
            b.r   = a.r | (C_ROOT_W'(1) << k);
        end
        return b;
    endfunction

endpackage

`default_nettype wire

### hdl/ptas_prep.sv
`default_nettype none

module ptas_prep (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire                    i_action,
    input  wire  [16:0]            i_front_pressure,
    input  wire  [16:0]            i_ambient_pressure,
    input  wire  signed [14:0]     i_temperature_c,
    input  wire  [15:0]            i_given_speed,
    output logic                   o_valid,
    input  wire                    i_ready,
    output ptas_pkg::t_lane        o_lane_i,
    output ptas_pkg::t_lane        o_lane_t,
    output ptas_pkg::t_side        o_side
);
    import ptas_pkg::*;

    logic        rdy1, rdy2, rdy3;
    logic        r1_v, r2_v, r3_v;

    logic        r1_mode;
    t_side       r1_side;
    logic [31:0] r1_gg;
    logic [37:0] r1_k1;
    logic [35:0] r1_dp287;
    logic [15:0] r1_tk;
    logic [36:0] r1_nias;
    logic [5:0]  r1_dias;
    logic [36:0] r1_dtas;

    logic        r2_mode;
    t_side       r2_side;
    logic [51:0] r2_pl;
    logic [50:0] r2_ph;
    logic [36:0] r2_nias;
    logic [5:0]  r2_dias;
    logic [36:0] r2_dtas;

    t_side       r3_side;
    logic [69:0] r3_ntas;
    logic [36:0] r3_nias;
    logic [5:0]  r3_dias;
    logic [36:0] r3_dtas;

    logic [16:0] dp;
    logic [16:0] tk_full;

    assign rdy3    = !r3_v || i_ready;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r3_v;

    always_comb begin
        dp      = (i_front_pressure >= i_ambient_pressure) ?
                  (i_front_pressure - i_ambient_pressure) : 17'd0;
        tk_full = {{2{i_temperature_c[14]}}, i_temperature_c} + C_T_ZERO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_mode      <= i_action;
            r1_side.neg  <= !i_action && (i_front_pressure < i_ambient_pressure);
            r1_side.zero <= (i_ambient_pressure == 17'd0);
            r1_gg        <= 32'(i_given_speed) * 32'(i_given_speed);
            r1_k1        <= 38'(C_COR_NUM) * 38'(tk_full[15:0]);
            r1_dp287     <= 36'(dp) * 36'(C_TAS_NUM);
            r1_tk        <= tk_full[15:0];
            r1_nias      <= i_action ? 37'(32'(i_given_speed) * 32'(i_given_speed))
                                     : 37'(C_IAS_NUM) * 37'(dp);
            r1_dias      <= i_action ? 6'd1 : C_IAS_DEN;
            r1_dtas      <= i_action ? 37'(C_COR_DEN) * 37'(i_ambient_pressure)
                                     : 37'(C_TAS_DEN) * 37'(i_ambient_pressure);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_mode <= r1_mode;
            r2_side <= r1_side;
            r2_pl   <= r1_mode ? 52'(r1_gg) * 52'(r1_k1[18:0])
                               : 52'(r1_dp287) * 52'(r1_tk);
            r2_ph   <= 51'(r1_gg) * 51'(r1_k1[37:19]);
            r2_nias <= r1_nias;
            r2_dias <= r1_dias;
            r2_dtas <= r1_dtas;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_side <= r2_side;
            r3_ntas <= r2_mode ? ({r2_ph, 19'd0} + 70'(r2_pl)) : 70'(r2_pl);
            r3_nias <= r2_nias;
            r3_dias <= r2_dias;
            r3_dtas <= r2_dtas;
        end
    end

    always_comb begin
        o_lane_i.rem = 70'(r3_nias);
        o_lane_i.rd  = '0;
        o_lane_i.d   = 37'(r3_dias);
        o_lane_i.r   = '0;
        o_lane_t.rem = r3_ntas;
        o_lane_t.rd  = '0;
        o_lane_t.d   = r3_dtas;
        o_lane_t.r   = '0;
        o_side       = r3_side;
    end

endmodule

`default_nettype wire

### hdl/ptas_sqrt.sv
`default_nettype none

module ptas_sqrt (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  ptas_pkg::t_lane        i_lane_i,
    input  ptas_pkg::t_lane        i_lane_t,
    input  ptas_pkg::t_side        i_side,
    output logic                   o_valid,
    input  wire                    i_ready,
    output ptas_pkg::t_lane        o_lane_i,
    output ptas_pkg::t_lane        o_lane_t,
    output ptas_pkg::t_side        o_side
);
    import ptas_pkg::*;

    logic  r_v    [C_STAGES];
    t_lane r_li   [C_STAGES];
    t_lane r_lt   [C_STAGES];
    t_side r_side [C_STAGES];
    logic  rdy    [C_STAGES+1];

    assign rdy[C_STAGES] = i_ready;
    assign o_ready       = rdy[0];

    genvar j;
    generate
        for (j = 0; j < C_STAGES; j++) begin : g_stage
            localparam logic [4:0] K = 5'(C_STAGES - 1 - j);
            logic  v_in;
            t_lane li_in, lt_in;
            t_side s_in;

            if (j == 0) begin : g_first
                assign v_in  = i_valid;
                assign li_in = i_lane_i;
                assign lt_in = i_lane_t;
                assign s_in  = i_side;
            end else begin : g_next
                assign v_in  = r_v[j-1];
                assign li_in = r_li[j-1];
                assign lt_in = r_lt[j-1];
                assign s_in  = r_side[j-1];
            end

            assign rdy[j] = !r_v[j] || rdy[j+1];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (rdy[j]) begin
                    r_v[j] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (rdy[j]) begin
                    r_li[j]   <= f_root_step(li_in, K);
                    r_lt[j]   <= f_root_step(lt_in, K);
                    r_side[j] <= s_in;
                end
            end
        end
    endgenerate

    assign o_valid  = r_v[C_STAGES-1];
    assign o_lane_i = r_li[C_STAGES-1];
    assign o_lane_t = r_lt[C_STAGES-1];
    assign o_side   = r_side[C_STAGES-1];

endmodule

`default_nettype wire

### hdl/pitot_true_airspeed.sv
// Pitot-static airspeed: indicated and true airspeed in cm/s, rounded down, from
// pitot and static pressure and air temperature (mode 0), or true airspeed from
// a given indicated speed (mode 1). Fully pipelined: one request per cycle while
// i_stall is low, through 3 multiply stages, then 17 stages of an exact restoring
// square root of a ratio, one root bit per stage, saturation bit first.
// Status: 2 zero static pressure, 3 saturated at 65535, 1 negative differential.
`default_nettype none

module pitot_true_airspeed (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire               i_action,
    input  wire  [16:0]       i_front_pressure,
    input  wire  [16:0]       i_ambient_pressure,
    input  wire  signed [14:0] i_temperature_c,
    input  wire  [15:0]       i_given_speed,
    output logic              o_valid,
    input  wire               i_stall,
    output logic [15:0]       o_indicated_speed,
    output logic [15:0]       o_true_speed,
    output logic [1:0]        o_status
);
    import ptas_pkg::*;

    logic  prep_ready, prep_valid, sq_ready;
    t_lane prep_li, prep_lt, sq_li, sq_lt;
    t_side prep_side, sq_side;
    logic  sat;

    ptas_prep u_prep (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (prep_ready),
        .i_action           (i_action),
        .i_front_pressure   (i_front_pressure),
        .i_ambient_pressure (i_ambient_pressure),
        .i_temperature_c    (i_temperature_c),
        .i_given_speed      (i_given_speed),
        .o_valid            (prep_valid),
        .i_ready            (sq_ready),
        .o_lane_i           (prep_li),
        .o_lane_t           (prep_lt),
        .o_side             (prep_side)
    );

    ptas_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (prep_valid),
        .o_ready  (sq_ready),
        .i_lane_i (prep_li),
        .i_lane_t (prep_lt),
        .i_side   (prep_side),
        .o_valid  (o_valid),
        .i_ready  (!i_stall),
        .o_lane_i (sq_li),
        .o_lane_t (sq_lt),
        .o_side   (sq_side)
    );

    assign o_stall = !prep_ready;

    always_comb begin
        sat               = sq_li.r[16] || sq_lt.r[16];
        o_indicated_speed = sq_li.r[16] ? 16'hFFFF : sq_li.r[15:0];
        o_true_speed      = (sq_side.zero || sq_lt.r[16]) ? 16'hFFFF : sq_lt.r[15:0];
        if (sq_side.zero) begin
            o_status = ST_ZERO;
        end else if (sat) begin
            o_status = ST_SAT;
        end else if (sq_side.neg) begin
            o_status = ST_NEG;
        end else begin
            o_status = ST_OK;
        end
    end

    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ZERO |-> o_true_speed == 16'hFFFF)
        else $error("zero static pressure without saturated true speed");

    a_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NEG |-> o_indicated_speed == 16'd0 && o_true_speed == 16'd0)
        else $error("negative differential with nonzero speed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

### bench/tb_pitot_true_airspeed.sv
`default_nettype none

module tb_pitot_true_airspeed;
    import ptas_pkg::*;

    typedef struct {
        logic              action;
        logic [16:0]       front;
        logic [16:0]       amb;
        logic signed [14:0] temp;
        logic [15:0]       given;
        bit                known;
        logic [15:0]       ias;
        logic [15:0]       tas;
        t_status           status;
    } t_request;

    typedef struct {
        logic [15:0] ias;
        logic [15:0] tas;
        t_status     status;
    } t_speeds;

    localparam int N_RANDOM = 430;
    localparam int HOLD_CYCLES = 80;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_action = 1'b0;
    logic [16:0]        i_front_pressure = '0;
    logic [16:0]        i_ambient_pressure = '0;
    logic signed [14:0] i_temperature_c = '0;
    logic [15:0]        i_given_speed = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [15:0]        o_indicated_speed;
    logic [15:0]        o_true_speed;
    logic [1:0]         o_status;

    t_speeds expected_speeds[$];
    int      errors = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      n_mode1 = 0;
    int      n_flagged = 0;
    bit      no_idle = 1'b0;
    bit      hold_off = 1'b0;

    pitot_true_airspeed dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    // floor(sqrt(n/d)), 65536 meaning saturated
    function automatic logic [16:0] root_of_ratio(logic [127:0] n, logic [127:0] d);
        logic [127:0] r;
        r = 0;
        if (d * 128'd65536 * 128'd65536 <= n) return 17'd65536;
        for (int b = 15; b >= 0; b--) begin
            if ((r | (128'd1 << b)) * (r | (128'd1 << b)) * d <= n) r = r | (128'd1 << b);
        end
        return r[16:0];
    endfunction

    function automatic t_speeds airspeed_of(t_request q);
        t_speeds      s;
        logic [127:0] tk, dp;
        logic [16:0]  ias, tas;
        bit           neg, sat, zero;
        tk   = 128'(int'(q.temp) + 27315);
        neg  = 1'b0;
        sat  = 1'b0;
        zero = (q.amb == 0);
        tas  = 17'd65535;
        if (q.action == 1'b0) begin
            neg = q.front < q.amb;
            dp  = neg ? 128'd0 : 128'(q.front - q.amb);
            ias = root_of_ratio(dp * 128'd800000, 128'd49);
            if (!zero) tas = root_of_ratio(dp * 128'd287052 * tk, 128'd5 * q.amb);
        end else begin
            ias = {1'b0, q.given};
            if (!zero) begin
                tas = root_of_ratio(128'(q.given) * q.given * 128'd3516387 * tk,
                                    128'd1000000 * q.amb);
            end
        end
        if (ias > 17'd65535) begin
            ias = 17'd65535;
            sat = 1'b1;
        end
        if (tas > 17'd65535) begin
            tas = 17'd65535;
            sat = 1'b1;
        end
        s.ias    = ias[15:0];
        s.tas    = tas[15:0];
        s.status = zero ? ST_ZERO : sat ? ST_SAT : neg ? ST_NEG : ST_OK;
        return s;
    endfunction

    function automatic t_request make_request(int act, int front, int amb, int temp,
                                              int given);
        t_request q;
        q.action = 1'(act);
        q.front  = 17'(front);
        q.amb    = 17'(amb);
        q.temp   = 15'(temp);
        q.given  = 16'(given);
        q.known  = 1'b0;
        q.ias    = '0;
        q.tas    = '0;
        q.status = ST_OK;
        return q;
    endfunction

    function automatic t_request with_result(t_request q, int ias, int tas, t_status st);
        q.known  = 1'b1;
        q.ias    = 16'(ias);
        q.tas    = 16'(tas);
        q.status = st;
        return q;
    endfunction

    function automatic t_request random_request();
        t_request q;
        int       kind;
        kind = $urandom_range(0, 99);
        q = make_request($urandom_range(0, 1), $urandom_range(0, 131071),
                         $urandom_range(0, 131071), $urandom_range(0, 18000) - 6000,
                         $urandom_range(0, 65535));
        if (kind < 55) begin
            q.action = 1'b0;
            q.amb    = 17'($urandom_range(20000, 110000));
            q.front  = q.amb + 17'($urandom_range(0, 131071 - int'(q.amb)));
        end else if (kind < 75) begin
            q.action = 1'b1;
            q.amb    = 17'($urandom_range(1000, 131071));
        end else if (kind < 80) begin
            q.amb = '0;
        end else if (kind < 88) begin
            q.temp = 15'($urandom_range(0, 32767));
        end
        return q;
    endfunction

    task automatic send_request(t_request q);
        i_valid            <= 1'b1;
        i_action           <= q.action;
        i_front_pressure   <= q.front;
        i_ambient_pressure <= q.amb;
        i_temperature_c    <= q.temp;
        i_given_speed      <= q.given;
        do begin
            @(negedge i_clk);
        end while (o_stall);
        if (q.known) expected_speeds.push_back('{q.ias, q.tas, q.status});
        else expected_speeds.push_back(airspeed_of(q));
        n_sent++;
        if (q.action) n_mode1++;
        if (q.amb == 0 || (!q.action && q.front < q.amb)) n_flagged++;
        @(posedge i_clk);
        if (!no_idle && $urandom_range(0, 99) < 34) begin
            i_valid <= 1'b0;
            i_action           <= 1'($urandom_range(0, 1));
            i_front_pressure   <= 17'($urandom);
            i_ambient_pressure <= 17'($urandom);
            i_temperature_c    <= 15'($urandom);
            i_given_speed      <= 16'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // receiver side
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
            i_stall <= !no_idle && ($urandom_range(0, 99) < 34);
        end
    end

    always @(negedge i_clk) begin
        t_speeds e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_speeds.size() == 0) begin
                $error("unexpected result ias=%0d tas=%0d status=%0d",
                       o_indicated_speed, o_true_speed, o_status);
                errors++;
            end else begin
                e = expected_speeds.pop_front();
                n_checked++;
                if (o_indicated_speed !== e.ias) begin
                    $error("indicated_speed expected %0d got %0d", e.ias, o_indicated_speed);
                    errors++;
                end
                if (o_true_speed !== e.tas) begin
                    $error("true_speed expected %0d got %0d", e.tas, o_true_speed);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status expected %0d got %0d", e.status, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_request directed[$];
        int       wait_cycles;
        directed = '{
            with_result(make_request(0, 0, 0, 0, 0), 0, 65535, ST_ZERO),
            with_result(make_request(0, 100, 200, 1500, 0), 0, 0, ST_NEG),
            with_result(make_request(0, 0, 131071, -6000, 65535), 0, 0, ST_NEG),
            make_request(0, 131071, 0, 12000, 0),
            make_request(0, 131071, 1, 12000, 0),
            make_request(0, 131071, 131070, -6000, 0),
            make_request(0, 101325, 101325, 1500, 0),
            make_request(0, 104000, 101325, 1500, 0),
            make_request(0, 131071, 30000, -16384, 0),
            make_request(0, 131071, 30000, 16383, 0),
            make_request(0, 70000, 60000, -1, 0),
            with_result(make_request(1, 0, 0, 0, 12345), 12345, 65535, ST_ZERO),
            with_result(make_request(1, 131071, 1, 12000, 65535), 65535, 65535, ST_SAT),
            with_result(make_request(1, 5000, 1000, 0, 0), 0, 0, ST_OK),
            make_request(1, 0, 131071, -6000, 65535),
            make_request(1, 131071, 101325, 1500, 10000),
            make_request(1, 0, 26500, -5650, 25000),
            make_request(1, 0, 50000, -16384, 1),
            make_request(1, 0, 80000, 16383, 40000)
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_request(directed[k]);
        for (int k = 0; k < N_RANDOM; k++) begin
            no_idle = (k >= 120 && k < 200);
            if (k == 250) hold_off = 1'b1;
            if (k == 330) begin
                i_valid <= 1'b0;
                wait (expected_speeds.size() == 0);
                @(posedge i_clk);
            end
            send_request(random_request());
        end
        i_valid <= 1'b0;
        no_idle = 1'b0;
        wait (expected_speeds.size() == 0);
        wait_cycles = 0;
        while (wait_cycles < 40) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        $display("%0d requests (%0d corrected, %0d zero-static or negative) gave %0d results",
                 n_sent, n_mode1, n_flagged, n_checked);
        $display("covered both modes, all status codes, stall hold-off and drain pause");
        if (errors == 0 && expected_speeds.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
